// ===== hdl/kvt_pkg.sv =====
// Shared types and constants of the key/value table.
`default_nettype none

package kvt_pkg;

  // Fixed item field widths
  localparam int KEY_W       = 32;
  localparam int VALUE_W     = 32;
  localparam int FUNC_W      = 3;
  localparam int COUNT_OUT_W = 5;

  // Default table size
  localparam int ENTRIES_DEF = 16;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_WRITE        = 3'd0;
  localparam logic [FUNC_W-1:0] FN_READ         = 3'd1;
  localparam logic [FUNC_W-1:0] FN_CONTAINS     = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE_KEY   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REMOVE_VALUE = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CLEAR        = 3'd5;

  // Operation token walking down the cell row
  typedef struct packed {
    logic               vld;
    logic [FUNC_W-1:0]  func;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic               hit;
    logic               free_seen;
    logic [VALUE_W-1:0] rd;
  } tok_t;

  // Insert broadcast to all cells
  typedef struct packed {
    logic               vld;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } ins_t;

endpackage

`default_nettype wire

// ===== hdl/kvt_cell.sv =====
// One table slot: holds a key, a value and a valid mark, and passes the token on.
`default_nettype none

module kvt_cell import kvt_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int INDEX   = 0,
  localparam int IDX_W  = $clog2(ENTRIES),
  localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
  input  wire              clk,
  input  wire              rst_n,
  input  tok_t             tok_i,
  input  wire  [IDX_W-1:0] fidx_i,
  input  wire  [CNT_W-1:0] del_i,
  input  ins_t             ins_i,
  input  wire  [IDX_W-1:0] ins_idx_i,
  output tok_t             tok_o,
  output logic [IDX_W-1:0] fidx_o,
  output logic [CNT_W-1:0] del_o
);

  logic               valid_r, valid_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  tok_t               tok_r, tok_nxt;
  logic [IDX_W-1:0]   fidx_r, fidx_nxt;
  logic [CNT_W-1:0]   del_r, del_nxt;
  logic               match_k, match_v, ins_here;

  assign match_k  = valid_r && (key_r == tok_i.key);
  assign match_v  = valid_r && (value_r == tok_i.value);
  assign ins_here = ins_i.vld && (ins_idx_i == IDX_W'(INDEX));

  // Local action of the passing token, plus the insert write
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    tok_nxt   = tok_i;
    fidx_nxt  = fidx_i;
    del_nxt   = del_i;
    if (tok_i.vld) begin
      case (tok_i.func)
        FN_WRITE: begin
          if (match_k) begin
            value_nxt   = tok_i.value;
            tok_nxt.hit = 1'b1;
          end
        end
        FN_READ: begin
          if (match_k) begin
            tok_nxt.rd  = value_r;
            tok_nxt.hit = 1'b1;
          end
        end
        FN_CONTAINS: begin
          if (match_k) begin
            tok_nxt.hit = 1'b1;
          end
        end
        FN_REMOVE_KEY: begin
          if (match_k) begin
            valid_nxt   = 1'b0;
            tok_nxt.hit = 1'b1;
            del_nxt     = del_i + CNT_W'(1);
          end
        end
        FN_REMOVE_VALUE: begin
          if (match_v) begin
            valid_nxt   = 1'b0;
            tok_nxt.hit = 1'b1;
            del_nxt     = del_i + CNT_W'(1);
          end
        end
        FN_CLEAR: begin
          valid_nxt = 1'b0;
        end
        default: begin
        end
      endcase
      // lowest free slot claims the token's insert position
      if (!valid_r && !tok_i.free_seen) begin
        tok_nxt.free_seen = 1'b1;
        fidx_nxt          = IDX_W'(INDEX);
      end
    end
    if (ins_here) begin
      valid_nxt = 1'b1;
      key_nxt   = ins_i.key;
      value_nxt = ins_i.value;
    end
  end

  // Control state and token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.func      <= tok_nxt.func;
    tok_r.key       <= tok_nxt.key;
    tok_r.value     <= tok_nxt.value;
    tok_r.hit       <= tok_nxt.hit;
    tok_r.free_seen <= tok_nxt.free_seen;
    tok_r.rd        <= tok_nxt.rd;
  end

  // Payload
  always_ff @(posedge clk) begin
    key_r           <= key_nxt;
    value_r         <= value_nxt;
    fidx_r          <= fidx_nxt;
    del_r           <= del_nxt;
  end

  assign tok_o  = tok_r;
  assign fidx_o = fidx_r;
  assign del_o  = del_r;

endmodule

`default_nettype wire

// ===== hdl/key_value_table.sv =====
// Key/value table: a row of ENTRIES slot cells walked by one operation token.
// The token passes the ENTRIES cell registers, then the result holding and output registers.
// No new item is accepted until the last result moves out; the token visits one cell per cycle.
// An insert is written into the chosen cell at the cycle the token leaves the row.
// Reset (synchronous, rst_n low) clears all valid marks, the count and control.
`default_nettype none

module key_value_table import kvt_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire  [FUNC_W-1:0]        in_func,
  input  wire  [KEY_W-1:0]         in_key,
  input  wire  [VALUE_W-1:0]       in_value,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic [VALUE_W-1:0]       out_read_value,
  output logic                     out_hit,
  output logic                     out_full_error,
  output logic [COUNT_OUT_W-1:0]   out_entry_count
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  tok_t               tok_w  [ENTRIES+1];
  logic [IDX_W-1:0]   fidx_w [ENTRIES+1];
  logic [CNT_W-1:0]   del_w  [ENTRIES+1];
  tok_t               tl;
  ins_t               ins;
  logic               accept, need_ins, do_ins, full;

  // Result holding and output registers
  logic               res_hit_r, res_full_r;
  logic [VALUE_W-1:0] res_rd_r;
  logic [CNT_W-1:0]   res_cnt_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_full_r;
  logic [VALUE_W-1:0] out_rd_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic               out_free, move_out;
  logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Token entering the first cell
  always_comb begin
    tok_w[0].vld       = accept;
    tok_w[0].func      = in_func;
    tok_w[0].key       = in_key;
    tok_w[0].value     = in_value;
    tok_w[0].hit       = 1'b0;
    tok_w[0].free_seen = 1'b0;
    tok_w[0].rd        = '0;
  end
  assign fidx_w[0] = '0;
  assign del_w[0]  = '0;

  // Cell row
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kvt_cell #(
      .ENTRIES (ENTRIES),
      .INDEX   (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tok_i     (tok_w[i]),
      .fidx_i    (fidx_w[i]),
      .del_i     (del_w[i]),
      .ins_i     (ins),
      .ins_idx_i (fidx_w[ENTRIES]),
      .tok_o     (tok_w[i+1]),
      .fidx_o    (fidx_w[i+1]),
      .del_o     (del_w[i+1])
    );
  end

  // Token leaving the row: finish insert and count
  assign tl       = tok_w[ENTRIES];
  assign need_ins = ((tl.func == FN_WRITE) || (tl.func == FN_READ)) && !tl.hit;
  assign do_ins   = tl.vld && need_ins && tl.free_seen;
  assign full     = need_ins && !tl.free_seen;

  always_comb begin
    ins.vld   = do_ins;
    ins.key   = tl.key;
    ins.value = (tl.func == FN_WRITE) ? tl.value : '0;
  end

  always_comb begin
    count_nxt = count_r;
    if (tl.vld) begin
      case (tl.func)
        FN_WRITE, FN_READ: begin
          if (do_ins) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        FN_REMOVE_KEY, FN_REMOVE_VALUE: begin
          count_nxt = count_r - del_w[ENTRIES];
        end
        FN_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  assign out_free = !out_valid_r || !out_stall;
  assign move_out = (state_r == ST_HOLD) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (tl.vld) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (move_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (tl.vld) begin
      res_hit_r  <= tl.hit && (tl.func != FN_CLEAR);
      res_full_r <= full;
      res_rd_r   <= (tl.func == FN_READ) ? tl.rd : '0;
      res_cnt_r  <= count_nxt;
    end
    if (move_out) begin
      out_hit_r  <= res_hit_r;
      out_full_r <= res_full_r;
      out_rd_r   <= res_rd_r;
      out_cnt_r  <= res_cnt_r;
    end
  end

  // Outputs
  assign cnt_ext         = {{COUNT_OUT_W{1'b0}}, out_cnt_r};
  assign out_valid       = out_valid_r;
  assign out_read_value  = out_rd_r;
  assign out_hit         = out_hit_r;
  assign out_full_error  = out_full_r;
  assign out_entry_count = cnt_ext[COUNT_OUT_W-1:0];

endmodule

`default_nettype wire
